// ===== hw/rtl/ctia_pkg.sv =====
// Shared types, opcodes and type-fitting helpers for the typed integer ALU.
`timescale 1ns / 1ps

package ctia_pkg;

  localparam int unsigned DataW     = 64;
  localparam int unsigned AccW      = 2 * DataW;
  localparam int unsigned NumCells  = DataW;
  localparam int unsigned InTdataW  = 144;
  localparam int unsigned OutTdataW = 64;

  // opcodes
  localparam logic [4:0] OP_ADD  = 5'd0;
  localparam logic [4:0] OP_SUB  = 5'd1;
  localparam logic [4:0] OP_MUL  = 5'd2;
  localparam logic [4:0] OP_DIV  = 5'd3;
  localparam logic [4:0] OP_MOD  = 5'd4;
  localparam logic [4:0] OP_AND  = 5'd5;
  localparam logic [4:0] OP_XOR  = 5'd6;
  localparam logic [4:0] OP_OR   = 5'd7;
  localparam logic [4:0] OP_SHL  = 5'd8;
  localparam logic [4:0] OP_SHR  = 5'd9;
  localparam logic [4:0] OP_EQ   = 5'd10;
  localparam logic [4:0] OP_NE   = 5'd11;
  localparam logic [4:0] OP_LT   = 5'd12;
  localparam logic [4:0] OP_LE   = 5'd13;
  localparam logic [4:0] OP_GT   = 5'd14;
  localparam logic [4:0] OP_GE   = 5'd15;
  localparam logic [4:0] OP_LAND = 5'd16;
  localparam logic [4:0] OP_LOR  = 5'd17;

  // width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;
  localparam logic [1:0] WC_64 = 2'd3;

  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_MUL,
    KIND_DIV,
    KIND_MOD
  } ctia_kind_e;

  // per-item control that rides along the cell chain
  typedef struct packed {
    ctia_kind_e        kind;
    logic              fail;       // failed before the chain
    logic              raw;        // compare / logical: no normalization
    logic              neg_q;      // product or quotient is negative
    logic              neg_r;      // remainder is negative
    logic              chk_ovf;    // signed multiply overflow check
    logic [1:0]        calc_wc;
    logic [1:0]        res_wc;
    logic              res_signed;
    logic              res_bool;
    logic [DataW-1:0]  value;      // finished result of ops that need no chain cells
  } ctia_ctl_t;

  // shared accumulator: {hi, lo} and the other operand (multiplicand or divisor)
  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [DataW-1:0] opd;
  } ctia_arith_t;

  // truncate to the coded width, then sign- or zero-extend back
  function automatic logic [DataW-1:0] fit_to(logic [DataW-1:0] v, logic [1:0] code,
                                              logic sgn);
    logic [DataW-1:0] r;
    r = v;
    unique case (code)
      WC_8:    r = {{56{sgn & v[7]}}, v[7:0]};
      WC_16:   r = {{48{sgn & v[15]}}, v[15:0]};
      WC_32:   r = {{32{sgn & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  // 2^(bits-1) as an unsigned value
  function automatic logic [DataW-1:0] top_bit(logic [1:0] code);
    logic [6:0] bits;
    bits = 7'd8 << code;
    return {{(DataW-1){1'b0}}, 1'b1} << (bits - 7'd1);
  endfunction

endpackage

// ===== hw/rtl/ctia_front.sv =====
// Operand fitting, checks and the operations that need no cell chain; loads the cell chain.
`timescale 1ns / 1ps

module ctia_front import ctia_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [InTdataW-1:0] tdata_i,
  output logic                valid_o,
  output ctia_ctl_t           ctl_o,
  output ctia_arith_t         arith_o
);

  logic [4:0]       op;
  logic [DataW-1:0] a, b, ul, ur, smin, smax, umax, mag_a, mag_b;
  logic [1:0]       cwc, nwc;
  logic             cs, ns, is_shift;
  logic [6:0]       bits;
  logic [DataW:0]   sum, dif, smax_x, smin_x;
  logic             add_ovf, sub_ovf, cnt_bad, shl_bad, div_bad, lt, eq;
  logic [5:0]       n;
  logic             valid_q;
  ctia_ctl_t        ctl_d, ctl_q;
  ctia_arith_t      arith_d, arith_q;

  assign op       = tdata_i[4:0];
  assign a        = tdata_i[68:5];
  assign b        = tdata_i[132:69];
  assign cwc      = tdata_i[134:133];
  assign cs       = tdata_i[135];
  assign nwc      = tdata_i[137:136];
  assign ns       = tdata_i[138];
  assign is_shift = (op == OP_SHL) || (op == OP_SHR);

  // operand promotion
  assign ul   = fit_to(a, cwc, cs);
  assign ur   = is_shift ? fit_to(b, nwc, ns) : fit_to(b, cwc, cs);
  assign bits = 7'd8 << cwc;
  assign smin = fit_to(top_bit(cwc), cwc, 1'b1);
  assign smax = ~smin;
  assign umax = fit_to({DataW{1'b1}}, cwc, 1'b0);

  // signed add / sub range checks on exact 65-bit results
  assign sum     = {ul[DataW-1], ul} + {ur[DataW-1], ur};
  assign dif     = {ul[DataW-1], ul} - {ur[DataW-1], ur};
  assign smax_x  = {smax[DataW-1], smax};
  assign smin_x  = {smin[DataW-1], smin};
  assign add_ovf = cs && (($signed(sum) > $signed(smax_x)) || ($signed(sum) < $signed(smin_x)));
  assign sub_ovf = cs && (($signed(dif) > $signed(smax_x)) || ($signed(dif) < $signed(smin_x)));

  // shift checks
  assign n       = ur[5:0];
  assign cnt_bad = (ns && ur[DataW-1]) || (ur >= {{(DataW-7){1'b0}}, bits});
  assign shl_bad = cs && (ul[DataW-1] || (ul > (umax >> n)));

  // divide checks and magnitudes
  assign div_bad = (ur == '0) || (cs && (ul == smin) && (ur == {DataW{1'b1}}));
  assign mag_a   = (cs && ul[DataW-1]) ? -ul : ul;
  assign mag_b   = (cs && ur[DataW-1]) ? -ur : ur;

  // compares
  assign eq = (ul == ur);
  assign lt = cs ? ($signed(ul) < $signed(ur)) : (ul < ur);

  // decode
  always_comb begin
    ctl_d            = '0;
    ctl_d.kind       = KIND_SIMPLE;
    ctl_d.calc_wc    = cwc;
    ctl_d.res_wc     = tdata_i[140:139];
    ctl_d.res_signed = tdata_i[141];
    ctl_d.res_bool   = tdata_i[142];
    arith_d.acc      = {{DataW{1'b0}}, mag_a};
    arith_d.opd      = mag_b;
    unique case (op)
      OP_ADD: begin
        ctl_d.fail  = add_ovf;
        ctl_d.value = ul + ur;
      end
      OP_SUB: begin
        ctl_d.fail  = sub_ovf;
        ctl_d.value = ul - ur;
      end
      OP_MUL: begin
        ctl_d.kind    = KIND_MUL;
        ctl_d.chk_ovf = cs;
        ctl_d.neg_q   = cs && (ul[DataW-1] ^ ur[DataW-1]);
        arith_d.acc   = {{DataW{1'b0}}, mag_b};
        arith_d.opd   = mag_a;
      end
      OP_DIV: begin
        ctl_d.kind  = KIND_DIV;
        ctl_d.fail  = div_bad;
        ctl_d.neg_q = cs && (ul[DataW-1] ^ ur[DataW-1]);
      end
      OP_MOD: begin
        ctl_d.kind  = KIND_MOD;
        ctl_d.fail  = div_bad;
        ctl_d.neg_r = cs && ul[DataW-1];
      end
      OP_AND: ctl_d.value = ul & ur;
      OP_XOR: ctl_d.value = ul ^ ur;
      OP_OR:  ctl_d.value = ul | ur;
      OP_SHL: begin
        ctl_d.fail  = cnt_bad || shl_bad;
        ctl_d.value = ul << n;
      end
      OP_SHR: begin
        ctl_d.fail  = cnt_bad;
        ctl_d.value = cs ? DataW'($signed(ul) >>> n) : (ul >> n);
      end
      OP_EQ: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, eq};
      end
      OP_NE: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, !eq};
      end
      OP_LT: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, lt};
      end
      OP_LE: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, lt || eq};
      end
      OP_GT: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, !(lt || eq)};
      end
      OP_GE: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, !lt};
      end
      OP_LAND: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, (a != '0) && (b != '0)};
      end
      OP_LOR: begin
        ctl_d.raw   = 1'b1;
        ctl_d.value = {{(DataW-1){1'b0}}, (a != '0) || (b != '0)};
      end
      default: ctl_d.fail = 1'b1;
    endcase
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q   <= ctl_d;
      arith_q <= arith_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign arith_o = arith_q;

endmodule

// ===== hw/rtl/ctia_cell.sv =====
// One chain cell: a shift-add multiply step or a restoring divide step.
`timescale 1ns / 1ps

module ctia_cell import ctia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  ctia_ctl_t   ctl_i,
  input  ctia_arith_t arith_i,
  output logic        valid_o,
  output ctia_ctl_t   ctl_o,
  output ctia_arith_t arith_o
);

  logic [DataW:0]  mul_sum, trial;
  logic [AccW-1:0] mul_acc, div_acc;
  logic            valid_q;
  ctia_ctl_t       ctl_q;
  ctia_arith_t     arith_d, arith_q;

  // multiply: add multiplicand on the low bit, shift right
  assign mul_sum = {1'b0, arith_i.acc[AccW-1:DataW]} +
                   (arith_i.acc[0] ? {1'b0, arith_i.opd} : '0);
  assign mul_acc = {mul_sum, arith_i.acc[DataW-1:1]};

  // divide: shift left, subtract divisor if it fits
  assign trial   = arith_i.acc[AccW-1:DataW-1] - {1'b0, arith_i.opd};
  assign div_acc = trial[DataW] ? {arith_i.acc[AccW-2:0], 1'b0}
                                : {trial[DataW-1:0], arith_i.acc[DataW-2:0], 1'b1};

  always_comb begin
    arith_d.opd = arith_i.opd;
    arith_d.acc = (ctl_i.kind == KIND_MUL) ? mul_acc : div_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q   <= ctl_i;
      arith_q <= arith_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign arith_o = arith_q;

endmodule

// ===== hw/rtl/ctia_back.sv =====
// Sign fix, multiply overflow check, result normalization and output register.
`timescale 1ns / 1ps

module ctia_back import ctia_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ctia_ctl_t            ctl_i,
  input  ctia_arith_t          arith_i,
  input  logic                 m_axis_tready,
  output logic                 m_axis_tvalid,
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic [0:0]           m_axis_tuser
);

  logic [DataW-1:0] lo, hi, lim, v, res_d, res_q;
  logic             mul_ovf, fail, ok_q, valid_q;

  assign lo = arith_i.acc[DataW-1:0];
  assign hi = arith_i.acc[AccW-1:DataW];

  // signed product must lie within the calculation type
  assign lim     = ctl_i.neg_q ? top_bit(ctl_i.calc_wc) : top_bit(ctl_i.calc_wc) - DataW'(1);
  assign mul_ovf = ctl_i.chk_ovf && ((hi != '0) || (lo > lim));
  assign fail    = ctl_i.fail || ((ctl_i.kind == KIND_MUL) && mul_ovf);

  always_comb begin
    unique case (ctl_i.kind)
      KIND_MUL, KIND_DIV: v = ctl_i.neg_q ? -lo : lo;
      KIND_MOD:           v = ctl_i.neg_r ? -hi : hi;
      default:            v = ctl_i.value;
    endcase
    priority if (fail) begin
      res_d = '0;
    end else if (ctl_i.raw) begin
      res_d = v;
    end else if (ctl_i.res_bool) begin
      res_d = {{(DataW-1){1'b0}}, v != '0};
    end else begin
      res_d = fit_to(v, ctl_i.res_wc, ctl_i.res_signed);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (en_i && valid_i) || (valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      res_q <= res_d;
      ok_q  <= !fail;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = ok_q;

endmodule

// ===== hw/rtl/checked_typed_integer_alu_unit.sv =====
// An accepted input beat passes the front stage, 64 multiply/divide cells and the output
// register, in that order, before it leaves as its output beat.
// Throughput: one beat per cycle; the 64-cell chain advances as a whole and
// holds only when the last cell is full and the output beat is not taken.
// Reset clears all valid bits; payload registers are not reset.
// Top level: typed integer ALU with overflow, divide and shift checks.
`timescale 1ns / 1ps

module checked_typed_integer_alu_unit import ctia_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [4:0] req_type, [68:5] left_operand, [132:69] right_operand,
  // [134:133] calc_width_code, [135] calc_signed, [137:136] count_width_code,
  // [138] count_signed, [140:139] result_width_code, [141] result_signed,
  // [142] result_is_bool, [143] zero pad
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [63:0] value
  output logic [0:0]           m_axis_tuser    // [0] ok
);

  logic        en;
  logic        cell_valid [NumCells+1];
  ctia_ctl_t   cell_ctl   [NumCells+1];
  ctia_arith_t cell_arith [NumCells+1];

  // chain moves unless the last cell and the output register are both stuck
  assign en            = !cell_valid[NumCells] || !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  ctia_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .tdata_i (s_axis_tdata),
    .valid_o (cell_valid[0]),
    .ctl_o   (cell_ctl[0]),
    .arith_o (cell_arith[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    ctia_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_valid[i]),
      .ctl_i   (cell_ctl[i]),
      .arith_i (cell_arith[i]),
      .valid_o (cell_valid[i+1]),
      .ctl_o   (cell_ctl[i+1]),
      .arith_o (cell_arith[i+1])
    );
  end

  ctia_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (cell_valid[NumCells]),
    .ctl_i         (cell_ctl[NumCells]),
    .arith_i       (cell_arith[NumCells]),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  // a failed beat always carries a zero value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("failed result with nonzero value");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // an accepted beat lands in the front stage
  a_front_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> cell_valid[0])
    else $error("accepted beat lost at front");

  // the last cell's beat moves into the output register
  a_back_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && cell_valid[NumCells] |=> m_axis_tvalid)
    else $error("beat lost at output");
`endif

endmodule

// ===== sim/checked_typed_integer_alu_unit_test.sv =====
// Testbench for the typed integer ALU: directed table, then random traffic with a predictor.
`timescale 1ns / 1ps

module checked_typed_integer_alu_unit_test;
  import ctia_pkg::*;

  localparam int unsigned RandomItems = 1800;
  localparam int unsigned WatchLimit  = 4000;
  localparam int unsigned DrainCycles = 100;
  localparam logic [4:0]  OpComma     = 5'd18;
  localparam logic [4:0]  OpTopCode   = 5'd31;

  typedef struct packed {
    logic       res_bool;
    logic       res_sgn;
    logic [1:0] res_wc;
    logic       cnt_sgn;
    logic [1:0] cnt_wc;
    logic       calc_sgn;
    logic [1:0] calc_wc;
    logic [63:0] rhs;
    logic [63:0] lhs;
    logic [4:0]  op;
  } alu_req_t;

  localparam int unsigned ReqW = $bits(alu_req_t);

  typedef struct packed {
    logic [63:0] value;
    logic        ok;
  } alu_res_t;

  // one directed row; has_exp marks a result typed in by hand
  typedef struct {
    alu_req_t req;
    logic     has_exp;
    alu_res_t exp;
  } vec_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  alu_res_t  pending_results[$];
  int        error_count;
  int        result_count;
  int        idle_cycles;
  bit        hold_off;
  vec_row_t  vec_table[$];

  checked_typed_integer_alu_unit DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] fit_width(logic [63:0] v, logic [1:0] wc, logic sgn);
    logic [63:0] m;
    int          bits;
    bits = 8 << wc;
    if (bits == 64) return v;
    m = (64'd1 << bits) - 64'd1;
    v &= m;
    if (sgn && v[bits-1]) v |= ~m;
    return v;
  endfunction

  function automatic alu_res_t alu_predict(alu_req_t r);
    alu_res_t          o;
    int                bits;
    logic signed [63:0] smax, smin, sl, sr;
    logic [63:0]       ul, ur, v, umax;
    logic signed [127:0] wide;
    logic              raw_flag;
    logic              fail;
    int                n;
    o = '0;
    fail = 1'b0;
    raw_flag = 1'b0;
    v = '0;
    bits = 8 << r.calc_wc;
    if (r.op == OP_LAND) begin
      o.value = 64'((r.lhs != 0) && (r.rhs != 0)); o.ok = 1'b1; return o;
    end
    if (r.op == OP_LOR) begin
      o.value = 64'((r.lhs != 0) || (r.rhs != 0)); o.ok = 1'b1; return o;
    end
    if (r.op > OP_LOR) return o;
    ul = fit_width(r.lhs, r.calc_wc, r.calc_sgn);
    if (r.op == OP_SHL || r.op == OP_SHR) ur = fit_width(r.rhs, r.cnt_wc, r.cnt_sgn);
    else ur = fit_width(r.rhs, r.calc_wc, r.calc_sgn);
    sl = ul;
    sr = ur;
    smax = (bits == 64) ? 64'h7fff_ffff_ffff_ffff : (64'd1 << (bits - 1)) - 1;
    smin = -smax - 1;
    // add, sub and mul overflow checks done in 128-bit signed arithmetic
    case (r.op)
      OP_ADD: begin
        wide = 128'(sl) + 128'(sr);
        if (r.calc_sgn && (wide > 128'(smax) || wide < 128'(smin))) fail = 1'b1;
        v = ul + ur;
      end
      OP_SUB: begin
        wide = 128'(sl) - 128'(sr);
        if (r.calc_sgn && (wide > 128'(smax) || wide < 128'(smin))) fail = 1'b1;
        v = ul - ur;
      end
      OP_MUL: begin
        wide = 128'(sl) * 128'(sr);
        if (r.calc_sgn && (wide > 128'(smax) || wide < 128'(smin))) fail = 1'b1;
        v = ul * ur;
      end
      OP_DIV, OP_MOD: begin
        if (ur == 0 || (r.calc_sgn && sl == smin && sr == -1)) fail = 1'b1;
        else if (r.calc_sgn) v = (r.op == OP_DIV) ? sl / sr : sl % sr;
        else v = (r.op == OP_DIV) ? ul / ur : ul % ur;
      end
      OP_AND: v = ul & ur;
      OP_XOR: v = ul ^ ur;
      OP_OR:  v = ul | ur;
      OP_SHL, OP_SHR: begin
        umax = (bits == 64) ? '1 : (64'd1 << bits) - 1;
        if ((r.cnt_sgn && sr < 0) || ur >= 64'(bits)) fail = 1'b1;
        else begin
          n = int'(ur[6:0]);
          if (r.op == OP_SHL) begin
            if (r.calc_sgn && (sl < 0 || ul > (umax >> n))) fail = 1'b1;
            v = ul << n;
          end else if (r.calc_sgn && sl < 0) v = ~((~ul) >> n);
          else v = ul >> n;
        end
      end
      default: begin
        raw_flag = 1'b1;
        case (r.op)
          OP_EQ: v = 64'(r.calc_sgn ? sl == sr : ul == ur);
          OP_NE: v = 64'(r.calc_sgn ? sl != sr : ul != ur);
          OP_LT: v = 64'(r.calc_sgn ? sl <  sr : ul <  ur);
          OP_LE: v = 64'(r.calc_sgn ? sl <= sr : ul <= ur);
          OP_GT: v = 64'(r.calc_sgn ? sl >  sr : ul >  ur);
          default: v = 64'(r.calc_sgn ? sl >= sr : ul >= ur);
        endcase
      end
    endcase
    if (fail) return o;
    o.ok = 1'b1;
    if (raw_flag) o.value = v;
    else if (r.res_bool) o.value = 64'(v != 0);
    else o.value = fit_width(v, r.res_wc, r.res_sgn);
    return o;
  endfunction

  // --------------------------------------------------------------- reporting
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %h want %h", result_count, what, got, want);
    error_count++;
  endtask

  // ------------------------------------------------------------ result check
  always @(posedge clk_i) begin
    alu_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.value) report_mismatch("value", m_axis_tdata, want.value);
        if (m_axis_tuser[0] !== want.ok) report_mismatch("ok", 64'(m_axis_tuser), 64'(want.ok));
      end
      result_count++;
    end
  end

  // -------------------------------------------------------- receiver stalls
  initial begin
    int phase;
    m_axis_tready = 1'b0;
    phase = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) m_axis_tready <= 1'b0;
      else if (phase % 600 < 150) m_axis_tready <= 1'b1;
      else if (phase % 600 < 400) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= ($urandom_range(0, 1) != 0);
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no beat for %0d cycles", WatchLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  task automatic send_beat(alu_req_t r);
    s_axis_tdata  <= InTdataW'(r);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(alu_predict(r));
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: x = '0;
      1: x = 64'($urandom_range(0, 70));
      2: x = -64'($urandom_range(1, 3));
      3: x = 64'h7fff_ffff_ffff_ffff;
      4: x = 64'h8000_0000_0000_0000;
      5: x = 64'd1 << $urandom_range(0, 63);
      6: x = 64'($signed($urandom_range(0, 255)) - 128);
      default: ;
    endcase
    return x;
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t r;
    r = ReqW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    r.op = ($urandom_range(0, 29) == 0) ? 5'($urandom_range(OpComma, OpTopCode))
                                        : 5'($urandom_range(OP_ADD, OP_LOR));
    r.lhs = rand_operand();
    r.rhs = rand_operand();
    if (r.op == OP_SHL || r.op == OP_SHR) begin
      if ($urandom_range(0, 3) != 0) r.rhs = 64'($urandom_range(0, (8 << r.calc_wc) - 1));
      if ($urandom_range(0, 1) != 0) r.lhs = 64'($urandom_range(0, 255));
    end
    return r;
  endfunction

  function automatic vec_row_t mk_row(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                                      logic [1:0] cw, logic cs, logic has_exp,
                                      logic [63:0] ev, logic eok);
    vec_row_t row;
    row.req = '0;
    row.req.op = op;
    row.req.lhs = a;
    row.req.rhs = b;
    row.req.calc_wc = cw;
    row.req.calc_sgn = cs;
    row.req.cnt_wc = WC_64;
    row.req.res_wc = WC_64;
    row.req.res_sgn = 1'b1;
    row.has_exp = has_exp;
    row.exp.value = ev;
    row.exp.ok = eok;
    return row;
  endfunction

  initial begin
    alu_req_t r;
    vec_row_t row;
    int       burst;
    error_count  = 0;
    result_count = 0;
    hold_off     = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: overflow edges, division traps, shift checks, every opcode
    vec_table.push_back(mk_row(OP_ADD, 64'd127, 64'd1, WC_8, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_ADD, 64'h7fff_ffff_ffff_ffff, 1, WC_64, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_ADD, '1, 64'd1, WC_64, 0, 1, 0, 1));
    vec_table.push_back(mk_row(OP_SUB, 64'h8000_0000_0000_0000, 1, WC_64, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_SUB, 64'd3, 64'd5, WC_16, 1, 1, -64'd2, 1));
    vec_table.push_back(mk_row(OP_MUL, 64'h4000_0000, 64'd2, WC_32, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_MUL, -64'd128, 64'd1, WC_8, 1, 0, 0, 0));
    vec_table.push_back(mk_row(OP_DIV, 64'd7, 64'd0, WC_32, 0, 1, 0, 0));
    vec_table.push_back(mk_row(OP_DIV, 64'h8000_0000_0000_0000, '1, WC_64, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_MOD, -64'd128, -64'd1, WC_8, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_MOD, -64'd7, 64'd2, WC_64, 1, 1, -64'd1, 1));
    vec_table.push_back(mk_row(OP_AND, '1, 64'hf0f0, WC_16, 0, 0, 0, 0));
    vec_table.push_back(mk_row(OP_XOR, '1, 64'h5a, WC_8, 1, 0, 0, 0));
    vec_table.push_back(mk_row(OP_OR, 64'h1234, 64'h8000_0000, WC_32, 0, 0, 0, 0));
    vec_table.push_back(mk_row(OP_SHL, 64'd1, 64'd64, WC_64, 0, 1, 0, 0));
    vec_table.push_back(mk_row(OP_SHL, 64'd1, 64'd63, WC_64, 1, 1, 64'h8000_0000_0000_0000, 1));
    vec_table.push_back(mk_row(OP_SHL, -64'd1, 64'd1, WC_32, 1, 1, 0, 0));
    vec_table.push_back(mk_row(OP_SHR, -64'd16, 64'd2, WC_64, 1, 1, -64'd4, 1));
    vec_table.push_back(mk_row(OP_SHR, 64'd16, -64'd1, WC_64, 0, 1, 0, 0));
    vec_table.push_back(mk_row(OP_EQ, 64'h1ff, 64'hff, WC_8, 0, 1, 64'd1, 1));
    vec_table.push_back(mk_row(OP_LT, -64'd1, 64'd0, WC_64, 1, 1, 64'd1, 1));
    vec_table.push_back(mk_row(OP_GE, -64'd1, 64'd0, WC_64, 0, 1, 64'd1, 1));
    vec_table.push_back(mk_row(OP_LAND, 64'h100, 64'd2, WC_8, 0, 1, 64'd1, 1));
    vec_table.push_back(mk_row(OP_LOR, 64'd0, 64'd0, WC_8, 0, 1, 64'd0, 1));
    vec_table.push_back(mk_row(OpComma, 64'd1, 64'd1, WC_64, 0, 1, 0, 0));
    // bool result, narrow unsigned result, ne/le/gt
    row = mk_row(OP_ADD, 64'd255, 64'd1, WC_16, 0, 0, 0, 0);
    row.req.res_bool = 1'b1;
    vec_table.push_back(row);
    row = mk_row(OP_SUB, 64'd0, 64'd1, WC_64, 0, 0, 0, 0);
    row.req.res_wc = WC_8;
    row.req.res_sgn = 1'b0;
    vec_table.push_back(row);
    vec_table.push_back(mk_row(OP_NE, 64'd1, 64'd2, WC_8, 1, 0, 0, 0));
    vec_table.push_back(mk_row(OP_LE, 64'd2, 64'd2, WC_8, 0, 0, 0, 0));
    vec_table.push_back(mk_row(OP_GT, 64'd3, -64'd2, WC_16, 1, 0, 0, 0));

    foreach (vec_table[i]) begin
      send_beat(vec_table[i].req);
      // hand-typed results replace the prediction for this row
      if (vec_table[i].has_exp) begin
        if (pending_results[$] !== vec_table[i].exp)
          report_mismatch("table vs predictor", pending_results[$].value,
                          vec_table[i].exp.value);
        pending_results[$] = vec_table[i].exp;
      end
    end

    // long receiver hold-off while input keeps coming: pipeline fills and stalls
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (100) send_beat(rand_req());
      end
    join

    // sender pauses until everything has drained
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    // random bursts with random gaps
    for (int k = 0; k < RandomItems; k += burst) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) send_beat(rand_req());
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d result beats: directed table of every opcode and trap, then",
             result_count);
    $display("random typed operands under bursty input, stalls and a long hold-off.");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
